>>> src/mavg_pkg.sv
package mavg_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int HEIGHT_W      = 11;
  localparam int SPAN_W        = 12;
  localparam int SAMPLE_MAX    = 4095;
  localparam int DEPTH_DEFAULT = 8;

  localparam int PERCENT_SCALE = 100;
  localparam int HEIGHT_LIMIT  = 1000;
  localparam int SPAN_RESET    = 984;

  // 100 * 4095 needs 19 bits
  localparam int PROD_W = 19;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_LANDED_LEVEL = 1'b0,
    REG_SPAN_COUNTS  = 1'b1
  } reg_index_t;

endpackage

>>> src/mavg_if.sv
interface mavg_sample_if import mavg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mavg_result_if import mavg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [SAMPLE_W-1:0] mean_level;
  logic signed [HEIGHT_W-1:0] height;

  modport source (output valid, output mean_level, output height, input ready);
  modport sink (input valid, input mean_level, input height, output ready);
endinterface

>>> src/adc_moving_average_height.sv
// Per sample: ring read and sum update, divide for the rounded mean, height
// multiply, divide for the height, output register. The bit-serial divider
// (DIV_W = 19 for every DEPTH up to 64) serves both divides. A new sample is
// taken only when idle, once the last result is in the output register.
// Reset (rst, synchronous): ring reads as all zeros, sum and write slot cleared,
// landed_level 0, span_counts 984, no result pending.
module adc_moving_average_height import mavg_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  mavg_sample_if.sink         samples,
  mavg_result_if.source       results
);

  localparam int AW     = $clog2(DEPTH);
  localparam int SUM_W  = $clog2(DEPTH * SAMPLE_MAX + 1);
  localparam int MNUM_W = $clog2(2 * DEPTH * SAMPLE_MAX + DEPTH + 1);
  localparam int DIV_W  = (MNUM_W > PROD_W) ? MNUM_W : PROD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MSTART,
    S_MWAIT,
    S_HMUL,
    S_HSTART,
    S_HWAIT,
    S_OUT
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] landed_level;
  logic [SPAN_W-1:0]   span_counts;
  logic                cfg_write;
  reg_index_t          cfg_index;

  logic [AW-1:0]       slot;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] mean;
  logic                neg;
  logic [PROD_W-1:0]   prod;

  logic                   div_start;
  logic [DIV_W-1:0]       div_numer;
  logic [SPAN_W-1:0]      div_denom;
  logic [DIV_W-1:0]       div_quot;
  logic                   div_busy;
  logic                   div_done;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0]      diff_mag;
  logic [HEIGHT_W-2:0]      h_mag;
  logic [HEIGHT_W-1:0]      h_val;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      landed_level <= '0;
      span_counts  <= SPAN_W'(SPAN_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LANDED_LEVEL: landed_level <= pwdata[SAMPLE_W-1:0];
        REG_SPAN_COUNTS:  span_counts  <= pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_LANDED_LEVEL: prdata = PDATA_W'(landed_level);
      REG_SPAN_COUNTS:  prdata = PDATA_W'(span_counts);
      default:          prdata = '0;
    endcase
  end

  mavg_ring #(.DEPTH(DEPTH)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .wr_en   (state == S_READ),
    .wr_data (sample_q),
    .rd_data (old_sample)
  );

  // the divider serves the mean first, then the height
  assign div_start = (state == S_MSTART) || (state == S_HSTART);
  assign div_numer = (state == S_MSTART) ?
                     DIV_W'({running_sum, 1'b0}) + DIV_W'(DEPTH) : DIV_W'(prod);
  assign div_denom = (state == S_MSTART) ? SPAN_W'(2 * DEPTH) :
                     ((span_counts == '0) ? SPAN_W'(1) : span_counts);

  mavg_div #(.NW(DIV_W), .DW(SPAN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .quotient (div_quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign diff     = $signed({1'b0, landed_level}) - $signed({1'b0, mean});
  assign diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

  // clamp the magnitude, then restore the sign
  assign h_mag = (div_quot > DIV_W'(HEIGHT_LIMIT)) ? (HEIGHT_W-1)'(HEIGHT_LIMIT)
                                                   : div_quot[HEIGHT_W-2:0];
  assign h_val = neg ? -{1'b0, h_mag} : {1'b0, h_mag};

  assign samples.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot          <= '0;
      running_sum   <= '0;
      results.valid <= 1'b0;
    end else begin
      // load the output register only once the previous beat has gone
      if (state == S_OUT && (!results.valid || results.ready)) begin
        results.mean_level <= mean;
        results.height     <= $signed(h_val);
        results.valid      <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample_q <= samples.sample;
            state    <= S_READ;
          end
        end
        S_READ: begin
          running_sum <= running_sum - SUM_W'(old_sample) + SUM_W'(sample_q);
          slot        <= (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
          state       <= S_MSTART;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (div_done) begin
            mean  <= div_quot[SAMPLE_W-1:0];
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          neg   <= diff[SAMPLE_W];
          prod  <= PROD_W'(diff_mag) * PROD_W'(PERCENT_SCALE);
          state <= S_HSTART;
        end
        S_HSTART: state <= S_HWAIT;
        S_HWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!results.valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= AW'(DEPTH - 1))
    else $error("write slot beyond ring depth");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    running_sum <= SUM_W'(DEPTH * SAMPLE_MAX))
    else $error("running sum exceeds ring capacity");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_MWAIT || state == S_HWAIT))
    else $error("divider busy outside a wait state");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |->
      (results.height <= HEIGHT_W'(HEIGHT_LIMIT) &&
       results.height >= -HEIGHT_W'(HEIGHT_LIMIT)))
    else $error("height beyond saturation limit");

endmodule

>>> src/mavg_ring.sv
module mavg_ring import mavg_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [AW-1:0]       slot,
  input  logic                wr_en,
  input  logic [SAMPLE_W-1:0] wr_data,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    written;
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
    rd_q <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      rd_written <= written[slot];
      if (wr_en) begin
        written[slot] <= 1'b1;
      end
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_written ? rd_q : '0;

endmodule

>>> src/mavg_div.sv
module mavg_div import mavg_pkg::*; #(
  parameter int NW = PROD_W,
  parameter int DW = SPAN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic [NW-1:0] quotient,
  output logic          busy,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] work;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] count;
  logic [DW:0]   rem_sh;
  logic [DW:0]   trial;

  // shift one numerator bit into the remainder and try the subtract
  assign rem_sh = {rem, work[NW-1]};
  assign trial  = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work  <= numer;
        den   <= denom;
        rem   <= '0;
        count <= CW'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        work  <= {work[NW-2:0], ~trial[DW]};
        rem   <= trial[DW] ? rem_sh[DW-1:0] : trial[DW-1:0];
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule
